// File: design/bfa_pkg.sv
// Shared types and constants for the bitmap lowest-free allocator.
package bfa_pkg;

    localparam int IDX_W   = 13;
    localparam int CNT_W   = 4;
    localparam int FREE_W  = 14;
    localparam int FU_W    = 5;
    localparam int WORD_W  = 32;
    localparam int BIT_W   = 5;
    localparam int LOW_W   = 6;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOSPACE     = 2'd1;
    localparam logic [1:0] ST_DOUBLE_FREE = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_NOSPACE,
        OP_BADFREE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] index;
    } cmd_t;

    typedef struct packed {
        logic init_done;
    } back_status_t;

    typedef struct packed {
        logic full;
    } queue_status_t;

endpackage

// File: design/bfa_if.sv
// Request, result and configuration channel interfaces of the allocator.
interface alloc_req_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [bfa_pkg::CNT_W-1:0] count;
    logic [bfa_pkg::IDX_W-1:0] index;

    modport source (output valid, kind, count, index, input ready);
    modport sink   (input valid, kind, count, index, output ready);
endinterface

interface alloc_res_if;
    logic                       valid;
    logic                       ready;
    logic [bfa_pkg::IDX_W-1:0]  index_res;
    logic [1:0]                 status;
    logic [bfa_pkg::FREE_W-1:0] free_left;
    logic                       last;

    modport source (output valid, index_res, status, free_left, last, input ready);
    modport sink   (input valid, index_res, status, free_left, last, output ready);
endinterface

interface cfg_wr_if;
    logic                     valid;
    logic                     ready;
    logic [bfa_pkg::FU_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: design/bfa_front.sv
// Front end: accepts request items and classifies them into queue commands.
module bfa_front #(
    parameter int BITMAP_WORDS = 256,
    parameter int MAX_REQUEST  = 12
) (
    alloc_req_if.sink              req,
    input  bfa_pkg::queue_status_t q_status,
    input  bfa_pkg::back_status_t  b_status,
    output logic                   push,
    output bfa_pkg::cmd_t          cmd
);

    localparam int unsigned TOTAL_BITS = BITMAP_WORDS * 32;

    assign req.ready = !q_status.full && b_status.init_done;
    assign push      = req.valid && req.ready;

    always_comb
    begin
        cmd.count = req.count;
        cmd.index = req.index;
        if (req.kind == bfa_pkg::KIND_FREE)
        begin
            if (32'(req.index) >= TOTAL_BITS)
                cmd.op = bfa_pkg::OP_BADFREE;
            else
                cmd.op = bfa_pkg::OP_FREE;
        end
        else
        begin
            if (req.count == '0 || 32'(req.count) > MAX_REQUEST)
                cmd.op = bfa_pkg::OP_NOSPACE;
            else
                cmd.op = bfa_pkg::OP_ALLOC;
        end
    end

endmodule

// File: design/bfa_cmd_queue.sv
// Two-entry command queue between the front end and the back end.
module bfa_cmd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  bfa_pkg::cmd_t          push_cmd,
    input  logic                   pop,
    output logic                   head_valid,
    output bfa_pkg::cmd_t          head_cmd,
    output bfa_pkg::queue_status_t status
);

    bfa_pkg::cmd_t                entry_reg [bfa_pkg::Q_DEPTH];
    logic [bfa_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [bfa_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [bfa_pkg::Q_PTR_W:0]    fill_reg;
    logic [bfa_pkg::Q_PTR_W:0]    fill_next;

    assign head_valid  = (fill_reg != '0);
    assign head_cmd    = entry_reg[rd_ptr_reg];
    assign status.full = (fill_reg == (bfa_pkg::Q_PTR_W+1)'(bfa_pkg::Q_DEPTH));

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

endmodule

// File: design/bfa_back.sv
// Back end: bitmap memory, word scan, claim and release, result register.
module bfa_back #(
    parameter int BITMAP_WORDS = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  bfa_pkg::cmd_t         q_cmd,
    output logic                  q_pop,
    output bfa_pkg::back_status_t status,
    cfg_wr_if.sink                cfg,
    alloc_res_if.source           res
);

    localparam int WA         = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int PW         = WA + bfa_pkg::BIT_W;
    localparam int TOTAL_BITS = BITMAP_WORDS * 32;
    localparam int FW         = $clog2(TOTAL_BITS + 1);
    localparam logic [WA-1:0] LAST_WORD = WA'(BITMAP_WORDS - 1);
    localparam logic [FW-1:0] FREE_RESET = FW'(TOTAL_BITS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_A_RD,
        S_A_LOAD,
        S_A_CLAIM,
        S_A_WR,
        S_F_RD,
        S_F_DO,
        S_REPLY
    } state_t;

    function automatic logic [bfa_pkg::BIT_W-1:0] lowest_zero(input logic [31:0] w);
        logic [bfa_pkg::BIT_W-1:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!w[i])
                r = bfa_pkg::BIT_W'(i);
        end
        return r;
    endfunction

    logic [bfa_pkg::WORD_W-1:0] mem [BITMAP_WORDS];

    state_t                      state_reg;
    bfa_pkg::cmd_t               cmd_reg;
    logic [WA-1:0]               word_idx_reg;
    logic [bfa_pkg::CNT_W-1:0]   remaining_reg;
    logic [bfa_pkg::WORD_W-1:0]  work_reg;
    logic [bfa_pkg::WORD_W-1:0]  rd_data_reg;
    logic [bfa_pkg::WORD_W-1:0]  shadow_reg;
    logic [bfa_pkg::LOW_W-1:0]   low_free_reg;
    logic [FW-1:0]               free_total_reg;
    logic [bfa_pkg::FU_W-1:0]    first_usable_reg;
    logic                        out_valid_reg;
    logic [bfa_pkg::IDX_W-1:0]   out_index_reg;
    logic [1:0]                  out_status_reg;
    logic [bfa_pkg::FREE_W-1:0]  out_free_reg;
    logic                        out_last_reg;

    logic [bfa_pkg::WORD_W-1:0]  rsv_mask;
    logic [bfa_pkg::WORD_W-1:0]  search;
    logic [bfa_pkg::BIT_W-1:0]   claim_bit;
    logic                        slot_free;
    logic [FW-1:0]               usable;
    logic                        no_room;
    logic                        free_bit;
    logic [FW-1:0]               free_dec;
    logic                        mem_we;
    logic                        mem_re;
    logic [bfa_pkg::WORD_W-1:0]  mem_wdata;
    logic                        out_load;

    assign rsv_mask  = (32'h1 << first_usable_reg) - 32'h1;
    assign search    = work_reg | ((word_idx_reg == '0) ? rsv_mask : '0);
    assign claim_bit = lowest_zero(search);
    assign slot_free = !out_valid_reg || res.ready;
    assign usable    = free_total_reg - FW'(low_free_reg);
    assign no_room   = usable < FW'(cmd_reg.count);
    assign free_bit  = rd_data_reg[cmd_reg.index[bfa_pkg::BIT_W-1:0]];
    assign free_dec  = (free_total_reg != '0) ? free_total_reg - FW'(1) : free_total_reg;

    // a new result item enters the output register this cycle
    assign out_load = slot_free && (((state_reg == S_CHECK) && no_room) ||
                      ((state_reg == S_A_CLAIM) && remaining_reg != '0 && search != '1) ||
                      (state_reg == S_F_DO) || (state_reg == S_REPLY));

    assign q_pop            = (state_reg == S_IDLE) && q_valid;
    assign status.init_done = (state_reg != S_CLEAR);
    assign cfg.ready        = 1'b1;

    assign res.valid     = out_valid_reg;
    assign res.index_res = out_index_reg;
    assign res.status    = out_status_reg;
    assign res.free_left = out_free_reg;
    assign res.last      = out_last_reg;

    assign mem_re = (state_reg == S_A_RD) || (state_reg == S_F_RD);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        if (state_reg == S_CLEAR)
            mem_we = 1'b1;
        else if (state_reg == S_A_WR)
        begin
            mem_we    = 1'b1;
            mem_wdata = work_reg;
        end
        else if (state_reg == S_F_DO && slot_free && free_bit)
        begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_reg & ~(32'h1 << cmd_reg.index[bfa_pkg::BIT_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[word_idx_reg] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[word_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            cmd_reg          <= '0;
            word_idx_reg     <= '0;
            remaining_reg    <= '0;
            work_reg         <= '0;
            shadow_reg       <= '0;
            low_free_reg     <= '0;
            free_total_reg   <= FREE_RESET;
            first_usable_reg <= '0;
            out_valid_reg    <= 1'b0;
            out_index_reg    <= '0;
            out_status_reg   <= bfa_pkg::ST_OK;
            out_free_reg     <= '0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            // free entries below first_usable, from the word 0 copy
            low_free_reg <= bfa_pkg::LOW_W'($countones(~shadow_reg & rsv_mask));
            if (cfg.valid)
                first_usable_reg <= cfg.data;
            if (mem_we && word_idx_reg == '0)
                shadow_reg <= mem_wdata;
            out_valid_reg <= out_load || (out_valid_reg && !res.ready);

            unique case (state_reg)
                S_CLEAR:
                begin
                    word_idx_reg <= word_idx_reg + 1'b1;
                    if (word_idx_reg == LAST_WORD)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg       <= q_cmd;
                        word_idx_reg  <= WA'(q_cmd.index >> bfa_pkg::BIT_W);
                        remaining_reg <= q_cmd.count;
                        unique case (q_cmd.op)
                            bfa_pkg::OP_ALLOC:   state_reg <= S_CHECK;
                            bfa_pkg::OP_FREE:    state_reg <= S_F_RD;
                            bfa_pkg::OP_NOSPACE: state_reg <= S_REPLY;
                            bfa_pkg::OP_BADFREE: state_reg <= S_REPLY;
                        endcase
                    end
                end
                S_CHECK:
                begin
                    if (no_room)
                    begin
                        if (slot_free)
                        begin
                            out_index_reg  <= '0;
                            out_status_reg <= bfa_pkg::ST_NOSPACE;
                            out_free_reg   <= bfa_pkg::FREE_W'(free_total_reg);
                            out_last_reg   <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                    end
                    else
                    begin
                        word_idx_reg <= '0;
                        state_reg    <= S_A_RD;
                    end
                end
                S_A_RD:
                    state_reg <= S_A_LOAD;
                S_A_LOAD:
                begin
                    work_reg  <= rd_data_reg;
                    state_reg <= S_A_CLAIM;
                end
                S_A_CLAIM:
                begin
                    if (remaining_reg == '0 || search == '1)
                        state_reg <= S_A_WR;
                    else if (slot_free)
                    begin
                        work_reg[claim_bit] <= 1'b1;
                        remaining_reg       <= remaining_reg - 1'b1;
                        free_total_reg      <= free_dec;
                        out_index_reg       <= bfa_pkg::IDX_W'(PW'({word_idx_reg, claim_bit}));
                        out_status_reg      <= bfa_pkg::ST_OK;
                        out_free_reg        <= bfa_pkg::FREE_W'(free_dec);
                        out_last_reg        <= (remaining_reg == bfa_pkg::CNT_W'(1));
                    end
                end
                S_A_WR:
                begin
                    if (remaining_reg == '0)
                        state_reg <= S_IDLE;
                    else
                    begin
                        word_idx_reg <= word_idx_reg + 1'b1;
                        state_reg    <= S_A_RD;
                    end
                end
                S_F_RD:
                    state_reg <= S_F_DO;
                S_F_DO:
                begin
                    if (slot_free)
                    begin
                        out_index_reg <= cmd_reg.index;
                        out_last_reg  <= 1'b1;
                        if (free_bit)
                        begin
                            free_total_reg <= free_total_reg + FW'(1);
                            out_status_reg <= bfa_pkg::ST_OK;
                            out_free_reg   <= bfa_pkg::FREE_W'(free_total_reg + FW'(1));
                        end
                        else
                        begin
                            out_status_reg <= bfa_pkg::ST_DOUBLE_FREE;
                            out_free_reg   <= bfa_pkg::FREE_W'(free_total_reg);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_REPLY:
                begin
                    if (slot_free)
                    begin
                        out_free_reg  <= bfa_pkg::FREE_W'(free_total_reg);
                        out_last_reg  <= 1'b1;
                        if (cmd_reg.op == bfa_pkg::OP_NOSPACE)
                        begin
                            out_index_reg  <= '0;
                            out_status_reg <= bfa_pkg::ST_NOSPACE;
                        end
                        else
                        begin
                            out_index_reg  <= cmd_reg.index;
                            out_status_reg <= bfa_pkg::ST_DOUBLE_FREE;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: design/bitmap_lowest_free_allocator_core.sv
// Top level of the bitmap lowest-free allocator.
// After reset the block sweeps the bitmap memory to all free, one word per
// cycle; req.ready stays low until the sweep ends.
// Items are taken one at a time by the back end, with up to two more held in
// the command queue. A free reads the bitmap word, then clears the bit if set;
// a rejected request goes straight to its reply; an allocate reads, loads,
// claims one entry at a time and writes back each bitmap word it touches,
// using the single memory port that reads and writes one 32-bit word per
// pass. A result waits in an output register while the front end keeps
// taking items. first_usable may be written only while the block is idle.
module bitmap_lowest_free_allocator_core #(
    parameter int BITMAP_WORDS = 256,
    parameter int MAX_REQUEST  = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    alloc_req_if.sink   req,
    alloc_res_if.source res,
    cfg_wr_if.sink      cfg
);

    logic                   push;
    bfa_pkg::cmd_t          push_cmd;
    logic                   pop;
    logic                   head_valid;
    bfa_pkg::cmd_t          head_cmd;
    bfa_pkg::queue_status_t q_status;
    bfa_pkg::back_status_t  b_status;

    bfa_front #(
        .BITMAP_WORDS (BITMAP_WORDS),
        .MAX_REQUEST  (MAX_REQUEST)
    ) u_front (
        .req      (req),
        .q_status (q_status),
        .b_status (b_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    bfa_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .status     (q_status)
    );

    bfa_back #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (head_valid),
        .q_cmd   (head_cmd),
        .q_pop   (pop),
        .status  (b_status),
        .cfg     (cfg),
        .res     (res)
    );

endmodule

// File: design/bfa_checker.sv
// Port-level checks of the allocator and their bind to the top level.
module bfa_checker #(
    parameter int BITMAP_WORDS = 256
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [bfa_pkg::IDX_W-1:0]  res_index_res,
    input logic [1:0]                 res_status,
    input logic [bfa_pkg::FREE_W-1:0] res_free_left,
    input logic                       res_last
);

    localparam int unsigned TOTAL_BITS = BITMAP_WORDS * 32;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid
            && $stable({res_index_res, res_status, res_free_left, res_last}))
        else $error("result item changed while stalled");

    a_nospace_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == bfa_pkg::ST_NOSPACE |-> res_last && res_index_res == '0)
        else $error("no-space result not a single last item with index 0");

    a_double_free_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == bfa_pkg::ST_DOUBLE_FREE |-> res_last)
        else $error("double-free result not marked last");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> 32'(res_free_left) <= TOTAL_BITS)
        else $error("free count above group size");

endmodule

bind bitmap_lowest_free_allocator_core bfa_checker #(
    .BITMAP_WORDS (BITMAP_WORDS)
) u_bfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_index_res (res.index_res),
    .res_status    (res.status),
    .res_free_left (res.free_left),
    .res_last      (res.last)
);
